// File: rtl/core/bmq_pkg.sv
`timescale 1ns / 1ps

package bmq_pkg;

	// Sizing of the queue set
	localparam int NUM_QUEUES  = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int DATA_WIDTH  = 32;

	// Fixed field widths of the channels
	localparam int ACTION_W = 3;
	localparam int QID_W    = 3;
	localparam int DIN_W    = 32;
	localparam int SLOT_W   = 3;
	localparam int FRONT_W  = 32;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	// Derived internal widths
	localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

	typedef logic [QIDX_W-1:0]     qidx_t;
	typedef logic [PTR_W-1:0]      ptr_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [DATA_WIDTH-1:0] word_t;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_OPEN  = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_CLOSE = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_PUSH  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_POP   = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_PEEK  = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FREE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

	localparam cnt_t CNT_FULL = CNT_W'(QUEUE_DEPTH);
	localparam ptr_t PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} bmq_cmd_t;

	function automatic logic qid_in_range(input logic [QID_W-1:0] qid);
		return (32'(qid) < NUM_QUEUES);
	endfunction

	function automatic qidx_t qid_to_idx(input logic [QID_W-1:0] qid);
		logic [QIDX_W+QID_W-1:0] ext;
		ext = {{QIDX_W{1'b0}}, qid};
		return ext[QIDX_W-1:0];
	endfunction

	function automatic logic [SLOT_W-1:0] idx_to_slot(input qidx_t idx);
		logic [QIDX_W+SLOT_W-1:0] ext;
		ext = {{SLOT_W{1'b0}}, idx};
		return ext[SLOT_W-1:0];
	endfunction

	function automatic logic [COUNT_W-1:0] cnt_to_field(input cnt_t c);
		logic [CNT_W+COUNT_W-1:0] ext;
		ext = {{COUNT_W{1'b0}}, c};
		return ext[COUNT_W-1:0];
	endfunction

	function automatic word_t din_to_word(input logic [DIN_W-1:0] d);
		logic [DATA_WIDTH+DIN_W-1:0] ext;
		ext = {{DATA_WIDTH{1'b0}}, d};
		return ext[DATA_WIDTH-1:0];
	endfunction

	function automatic logic [FRONT_W-1:0] word_to_front(input word_t w);
		logic [DATA_WIDTH+FRONT_W-1:0] ext;
		ext = {{FRONT_W{1'b0}}, w};
		return ext[FRONT_W-1:0];
	endfunction

	function automatic ptr_t next_ptr(input ptr_t p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

// File: rtl/core/bmq_if.sv
`timescale 1ns / 1ps

interface bmq_in_if;
	import bmq_pkg::*;

	logic               valid;
	logic               ready;
	logic [ACTION_W-1:0] action;
	logic [QID_W-1:0]   queue_id;
	logic [DIN_W-1:0]   data_in;

	modport source (output valid, action, queue_id, data_in, input ready);
	modport sink   (input valid, action, queue_id, data_in, output ready);
endinterface

interface bmq_out_if;
	import bmq_pkg::*;

	logic                valid;
	logic                ready;
	logic [SLOT_W-1:0]   slot_out;
	logic [FRONT_W-1:0]  front_data;
	logic [COUNT_W-1:0]  entry_count;
	logic [STATUS_W-1:0] status;

	modport source (output valid, slot_out, front_data, entry_count, status, input ready);
	modport sink   (input valid, slot_out, front_data, entry_count, status, output ready);
endinterface

// File: rtl/core/broadcast_multi_queue.sv
`timescale 1ns / 1ps

// Channel  Role    Fields
// cmd      sink    action, queue_id, data_in
// rsp      source  slot_out, front_data, entry_count, status
//
// A word is captured at its accepting edge, then executed in the EXEC state (queue state
// update, bank write or bank read) and loaded into the output register in the LOAD state,
// which waits while a held result is not taken. The bank read for peek is registered in
// the RAM and sets the load cycle. After the load the block returns to idle and takes
// the next word; it handles one word at a time.
// Reset (arst_n low) frees every slot and empties every queue at once;
// the data banks are not cleared, reads are gated by the fill counts.
// A stalled result holds in the output register; the next word is taken
// only after the current one has been loaded there.

module broadcast_multi_queue import bmq_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	bmq_in_if.sink        cmd,
	bmq_out_if.source     rsp
);

	bmq_cmd_t dp_cmd;

	// sequencing: accept, execute, load into the output register
	bmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (dp_cmd)
	);

	// queue slots, per-queue banks and the result register
	bmq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.action      (cmd.action),
		.queue_id    (cmd.queue_id),
		.data_in     (cmd.data_in),
		.slot_out    (rsp.slot_out),
		.front_data  (rsp.front_data),
		.entry_count (rsp.entry_count),
		.status      (rsp.status)
	);

endmodule

// File: rtl/core/bmq_ram.sv
`timescale 1ns / 1ps

module bmq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/bmq_ctrl.sv
`timescale 1ns / 1ps

module bmq_ctrl import bmq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output bmq_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_LOAD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free    = !out_valid_q || out_ready;
	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.capture = in_valid && in_ready;
	assign cmd.exec    = (state_q == S_EXEC);
	assign cmd.load    = (state_q == S_LOAD) && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.capture) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_LOAD;
			end
			S_LOAD: begin
				if (out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a loaded result shows on the output next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid_q)
		else $error("loaded result not presented");

	// never overwrite a result that is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.load)
		else $error("held result overwritten");

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.exec, cmd.load}))
		else $error("overlapping datapath commands");

	a_capture_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.exec)
		else $error("captured word not executed");

endmodule

// File: rtl/core/bmq_dp.sv
`timescale 1ns / 1ps

module bmq_dp import bmq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  bmq_cmd_t            cmd,
	input  logic [ACTION_W-1:0] action,
	input  logic [QID_W-1:0]    queue_id,
	input  logic [DIN_W-1:0]    data_in,
	output logic [SLOT_W-1:0]   slot_out,
	output logic [FRONT_W-1:0]  front_data,
	output logic [COUNT_W-1:0]  entry_count,
	output logic [STATUS_W-1:0] status
);

	// captured word
	logic [ACTION_W-1:0] act_q;
	logic [QID_W-1:0]    qid_q;
	word_t               data_q;

	// per-queue control state
	logic  en_q   [NUM_QUEUES];
	ptr_t  head_q [NUM_QUEUES];
	ptr_t  tail_q [NUM_QUEUES];
	cnt_t  cnt_q  [NUM_QUEUES];

	// intermediate result
	logic [SLOT_W-1:0]   res_slot_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                res_open_q;
	logic                res_front_q;

	qidx_t idx;
	logic  qid_ok;
	logic  free_found;
	qidx_t free_idx;
	logic  wr_en [NUM_QUEUES];
	logic  overflow;
	logic  q_ready;
	word_t rdata [NUM_QUEUES];
	logic  rd_en;

	assign idx     = qid_to_idx(qid_q);
	assign qid_ok  = qid_in_range(qid_q);
	assign q_ready = qid_ok && en_q[idx] && (cnt_q[idx] != '0);
	assign rd_en   = cmd.exec && (act_q == ACT_PEEK);

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int q = NUM_QUEUES - 1; q >= 0; q--) begin
			if (!en_q[q]) begin
				free_found = 1'b1;
				free_idx   = QIDX_W'(q);
			end
		end
	end

	// broadcast: every enabled queue that is not full takes the word
	always_comb begin
		overflow = 1'b0;
		for (int q = 0; q < NUM_QUEUES; q++) begin
			wr_en[q] = 1'b0;
			if (en_q[q]) begin
				if (cnt_q[q] == CNT_FULL) begin
					overflow = 1'b1;
				end else begin
					wr_en[q] = cmd.exec && (act_q == ACT_PUSH);
				end
			end
		end
	end

	for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_bank
		bmq_ram #(
			.WIDTH (DATA_WIDTH),
			.DEPTH (QUEUE_DEPTH)
		) u_bank (
			.clk   (clk),
			.we    (wr_en[g]),
			.waddr (tail_q[g]),
			.wdata (data_q),
			.re    (rd_en),
			.raddr (head_q[idx]),
			.rdata (rdata[g])
		);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q  <= action;
			qid_q  <= queue_id;
			data_q <= din_to_word(data_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < NUM_QUEUES; q++) begin
				en_q[q]   <= 1'b0;
				head_q[q] <= '0;
				tail_q[q] <= '0;
				cnt_q[q]  <= '0;
			end
		end else if (cmd.exec) begin
			unique case (act_q)
				ACT_OPEN: begin
					if (free_found) begin
						en_q[free_idx]   <= 1'b1;
						head_q[free_idx] <= '0;
						tail_q[free_idx] <= '0;
						cnt_q[free_idx]  <= '0;
					end
				end
				ACT_CLOSE: begin
					if (qid_ok) begin
						en_q[idx]   <= 1'b0;
						head_q[idx] <= '0;
						tail_q[idx] <= '0;
						cnt_q[idx]  <= '0;
					end
				end
				ACT_PUSH: begin
					for (int q = 0; q < NUM_QUEUES; q++) begin
						if (wr_en[q]) begin
							tail_q[q] <= next_ptr(tail_q[q]);
							cnt_q[q]  <= cnt_q[q] + CNT_W'(1);
						end
					end
				end
				ACT_POP: begin
					if (q_ready) begin
						head_q[idx] <= next_ptr(head_q[idx]);
						cnt_q[idx]  <= cnt_q[idx] - CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_slot_q   <= qid_q;
			res_status_q <= ST_OK;
			res_open_q   <= 1'b0;
			res_front_q  <= 1'b0;
			unique case (act_q)
				ACT_OPEN: begin
					res_open_q   <= 1'b1;
					res_slot_q   <= free_found ? idx_to_slot(free_idx) : '0;
					res_status_q <= free_found ? ST_OK : ST_NO_FREE;
				end
				ACT_PUSH: begin
					res_status_q <= overflow ? ST_OVERFLOW : ST_OK;
				end
				ACT_POP: begin
					res_status_q <= q_ready ? ST_OK : ST_EMPTY;
				end
				ACT_PEEK: begin
					res_front_q  <= q_ready;
					res_status_q <= q_ready ? ST_OK : ST_EMPTY;
				end
				default: begin
				end
			endcase
		end
	end

	// counts are taken from the updated state; an open always reports an empty slot
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			slot_out    <= res_slot_q;
			status      <= res_status_q;
			front_data  <= res_front_q ? word_to_front(rdata[idx]) : '0;
			entry_count <= (res_open_q || !qid_ok) ? '0 : cnt_to_field(cnt_q[idx]);
		end
	end

endmodule
